@@ rtl/swr_pkg.sv @@
// Shared types and constants for the scale weight redistributor.
package swr_pkg;

	// Octave geometry and number format
	localparam int NSEMI     = 12;
	localparam int MAX_REACH = 6;
	localparam int FRAC_BITS = 15;
	localparam int W_BITS    = 16;
	localparam int DIST_W    = 3;
	localparam int MASK_W    = 12;

	// Partial sum over six neighbors, full sum over keep plus both sides
	localparam int SIDE_W = W_BITS + 3;
	localparam int ACC_W  = SIDE_W + 1;

	// 1.0 and the noise floor in raw units
	localparam logic [ACC_W-1:0]  ONE       = ACC_W'(1) << FRAC_BITS;
	localparam logic [W_BITS-1:0] FLOOR_RAW = W_BITS'((1 << FRAC_BITS) / 10000);

	// Mask value after reset: every semitone in scale
	localparam logic [MASK_W-1:0] MASK_RESET = '1;

	// Input request: weight_0 sits in the low bits
	typedef struct packed {
		logic [W_BITS-1:0] weight_11;
		logic [W_BITS-1:0] weight_10;
		logic [W_BITS-1:0] weight_9;
		logic [W_BITS-1:0] weight_8;
		logic [W_BITS-1:0] weight_7;
		logic [W_BITS-1:0] weight_6;
		logic [W_BITS-1:0] weight_5;
		logic [W_BITS-1:0] weight_4;
		logic [W_BITS-1:0] weight_3;
		logic [W_BITS-1:0] weight_2;
		logic [W_BITS-1:0] weight_1;
		logic [W_BITS-1:0] weight_0;
	} weights_t;

	// Output request: moved_0 sits in the low bits
	typedef struct packed {
		logic [W_BITS-1:0] moved_11;
		logic [W_BITS-1:0] moved_10;
		logic [W_BITS-1:0] moved_9;
		logic [W_BITS-1:0] moved_8;
		logic [W_BITS-1:0] moved_7;
		logic [W_BITS-1:0] moved_6;
		logic [W_BITS-1:0] moved_5;
		logic [W_BITS-1:0] moved_4;
		logic [W_BITS-1:0] moved_3;
		logic [W_BITS-1:0] moved_2;
		logic [W_BITS-1:0] moved_1;
		logic [W_BITS-1:0] moved_0;
	} moved_t;

endpackage

@@ rtl/scale_weight_redistributor_unit.sv @@
// Scale weight redistributor: three-stage pipeline moving out-of-scale weights.
//
//  channel   handshake             payload
//  weights   weights_valid/stall   swr_pkg::weights_t (twelve 16-bit weights)
//  moved     moved_valid/stall     swr_pkg::moved_t   (twelve 16-bit results)
//  cfg       cfg_valid/ready       12-bit scale mask
//
// One request per cycle while moved is not stalled; stages: routing (s1), neighbor sums (s2),
// final add and saturation (s3, also the output register).
// Reset (arst_n low) empties the pipeline and sets the mask to all semitones.
// A stall on moved holds s3 and backs up stage by stage; a stage only blocks
// its input when it is full and cannot move on, so bubbles are squeezed out.
// cfg_ready is always high; the mask must only change while the pipe is empty.
module scale_weight_redistributor_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      weights_valid,
	output logic                      weights_stall,
	input  swr_pkg::weights_t         weights,
	output logic                      moved_valid,
	input  logic                      moved_stall,
	output swr_pkg::moved_t           moved,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [swr_pkg::MASK_W-1:0] cfg_data
);
	import swr_pkg::*;

	// Config register
	logic [MASK_W-1:0] mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mask_q <= cfg_data;
		end
	end

	// Pipeline flow control
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	assign adv3          = !v_s3 || !moved_stall;
	assign adv2          = !v_s2 || adv3;
	assign adv1          = !v_s1 || adv2;
	assign weights_stall = !adv1;
	assign moved_valid   = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= weights_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// Unpack the input request
	logic [NSEMI*W_BITS-1:0] w_flat;
	logic [W_BITS-1:0]       w [NSEMI];

	assign w_flat = weights;

	always_comb begin
		for (int i = 0; i < NSEMI; i++) begin
			w[i] = w_flat[i*W_BITS +: W_BITS];
		end
	end

	// Stage 1: find nearest in-scale neighbor each way, split the weight
	logic [W_BITS-1:0] keep_c   [NSEMI];
	logic [W_BITS-1:0] amt_up_c [NSEMI];
	logic [W_BITS-1:0] amt_dn_c [NSEMI];
	logic [DIST_W-1:0] up_d_c   [NSEMI];
	logic [DIST_W-1:0] dn_d_c   [NSEMI];

	always_comb begin
		logic [DIST_W-1:0] up;
		logic [DIST_W-1:0] dn;
		logic              move;
		logic              up_lt;
		logic              dn_lt;
		logic              tie;
		for (int i = 0; i < NSEMI; i++) begin
			up = '0;
			dn = '0;
			// descending scan leaves the nearest hit; zero means none
			for (int d = MAX_REACH; d >= 1; d--) begin
				if (mask_q[(i + d) % NSEMI]) up = DIST_W'(d);
				if (mask_q[(i + NSEMI - d) % NSEMI]) dn = DIST_W'(d);
			end
			move  = !mask_q[i] && (w[i] > FLOOR_RAW);
			up_lt = (up != '0) && ((dn == '0) || (up < dn));
			dn_lt = (dn != '0) && ((up == '0) || (dn < up));
			tie   = (up != '0) && (up == dn);

			keep_c[i]   = mask_q[i] ? w[i] : '0;
			amt_up_c[i] = '0;
			amt_dn_c[i] = '0;
			if (move && up_lt) amt_up_c[i] = w[i];
			if (move && dn_lt) amt_dn_c[i] = w[i];
			if (move && tie) begin
				amt_up_c[i] = w[i] >> 1;
				amt_dn_c[i] = w[i] >> 1;
			end
			up_d_c[i] = up;
			dn_d_c[i] = dn;
		end
	end

	logic [W_BITS-1:0] keep_s1   [NSEMI];
	logic [W_BITS-1:0] amt_up_s1 [NSEMI];
	logic [W_BITS-1:0] amt_dn_s1 [NSEMI];
	logic [DIST_W-1:0] up_d_s1   [NSEMI];
	logic [DIST_W-1:0] dn_d_s1   [NSEMI];

	always_ff @(posedge clk) begin
		if (adv1) begin
			keep_s1   <= keep_c;
			amt_up_s1 <= amt_up_c;
			amt_dn_s1 <= amt_dn_c;
			up_d_s1   <= up_d_c;
			dn_d_s1   <= dn_d_c;
		end
	end

	// Stage 2: gather what lands on each semitone from below and from above
	logic [SIDE_W-1:0] lo_c [NSEMI];
	logic [SIDE_W-1:0] hi_c [NSEMI];

	always_comb begin
		for (int j = 0; j < NSEMI; j++) begin
			lo_c[j] = '0;
			hi_c[j] = '0;
			for (int d = 1; d <= MAX_REACH; d++) begin
				if (up_d_s1[(j + NSEMI - d) % NSEMI] == DIST_W'(d))
					lo_c[j] = lo_c[j] + SIDE_W'(amt_up_s1[(j + NSEMI - d) % NSEMI]);
				if (dn_d_s1[(j + d) % NSEMI] == DIST_W'(d))
					hi_c[j] = hi_c[j] + SIDE_W'(amt_dn_s1[(j + d) % NSEMI]);
			end
		end
	end

	logic [W_BITS-1:0] keep_s2 [NSEMI];
	logic [SIDE_W-1:0] lo_s2   [NSEMI];
	logic [SIDE_W-1:0] hi_s2   [NSEMI];

	always_ff @(posedge clk) begin
		if (adv2) begin
			keep_s2 <= keep_s1;
			lo_s2   <= lo_c;
			hi_s2   <= hi_c;
		end
	end

	// Stage 3: total and saturate at 1.0
	logic [W_BITS-1:0] res_c [NSEMI];

	always_comb begin
		logic [ACC_W-1:0] total;
		for (int j = 0; j < NSEMI; j++) begin
			total    = ACC_W'(keep_s2[j]) + ACC_W'(lo_s2[j]) + ACC_W'(hi_s2[j]);
			res_c[j] = (total > ONE) ? ONE[W_BITS-1:0] : total[W_BITS-1:0];
		end
	end

	logic [W_BITS-1:0] res_s3 [NSEMI];

	always_ff @(posedge clk) begin
		if (adv3) begin
			res_s3 <= res_c;
		end
	end

	// Pack the output request
	logic [NSEMI*W_BITS-1:0] m_flat;

	always_comb begin
		for (int j = 0; j < NSEMI; j++) begin
			m_flat[j*W_BITS +: W_BITS] = res_s3[j];
		end
	end

	assign moved = m_flat;

	// Checks
	logic sat_ok;

	always_comb begin
		sat_ok = 1'b1;
		for (int j = 0; j < NSEMI; j++) begin
			if (ACC_W'(res_s3[j]) > ONE) sat_ok = 1'b0;
		end
	end

	// results never exceed 1.0
	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		moved_valid |-> sat_ok)
		else $error("result above 1.0");

	// input only blocked when every stage is full and the output is stalled
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		weights_stall |-> (v_s1 && v_s2 && v_s3 && moved_stall))
		else $error("input stalled with room in the pipeline");

	// a held result stays in place until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && moved_stall) |=> (v_s3 && $stable(m_flat)))
		else $error("stalled result lost or changed");

	// an accepted request reaches stage 1
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(weights_valid && !weights_stall) |=> v_s1)
		else $error("accepted request not captured");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for scale_weight_redistributor_unit: random and directed weight vectors.
module testbench;
	import swr_pkg::*;

	localparam int NOISE_FLOOR  = (1 << FRAC_BITS) / 10000;
	localparam int FULL_SCALE   = 1 << FRAC_BITS;
	localparam int NO_HIT       = MAX_REACH + 1;
	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASE_ITEMS  = 200;
	localparam int NUM_PHASES   = 10;
	localparam int HOLD_CYCLES  = 80;
	localparam int MAX_PRINTS   = 100;

	// Notable scale masks
	localparam logic [MASK_W-1:0] MASK_EMPTY = 12'h000;
	localparam logic [MASK_W-1:0] MASK_FULL  = 12'hFFF;
	localparam logic [MASK_W-1:0] MASK_ROOT  = 12'h001;
	localparam logic [MASK_W-1:0] MASK_TOP   = 12'h800;
	localparam logic [MASK_W-1:0] MASK_MAJOR = 12'hAB5;
	localparam logic [MASK_W-1:0] MASK_TRI   = 12'h041;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic weights_valid = 1'b0;
	logic weights_stall;
	weights_t weights = '0;
	logic moved_valid;
	logic moved_stall = 1'b0;
	moved_t moved;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [MASK_W-1:0] cfg_data = '0;

	weights_t weight_backlog [$];
	moved_t expected_moved [$];
	logic [MASK_W-1:0] active_mask = MASK_FULL;
	logic weights_taken = 1'b0;
	int weights_sent = 0;
	int moved_seen = 0;
	int mismatches = 0;
	int cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	scale_weight_redistributor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.weights_valid(weights_valid),
		.weights_stall(weights_stall),
		.weights(weights),
		.moved_valid(moved_valid),
		.moved_stall(moved_stall),
		.moved(moved),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Expected outcome: keep in-scale weights, push the rest above the noise floor to the nearest in-scale semitone
	function automatic moved_t redistribute(weights_t w_in, logic [MASK_W-1:0] mask);
		logic [W_BITS-1:0] v;
		int unsigned acc [NSEMI];
		int i, d, up, dn;
		moved_t r;
		for (i = 0; i < NSEMI; i++)
			acc[i] = mask[i] ? w_in[i*W_BITS +: W_BITS] : 0;
		for (i = 0; i < NSEMI; i++) begin
			v = w_in[i*W_BITS +: W_BITS];
			if (mask[i] || v <= NOISE_FLOOR)
				continue;
			up = NO_HIT;
			dn = NO_HIT;
			// walk inward so the nearest hit wins
			for (d = MAX_REACH; d >= 1; d--) begin
				if (mask[(i + d) % NSEMI])
					up = d;
				if (mask[(i + NSEMI - d) % NSEMI])
					dn = d;
			end
			if (up < dn) begin
				acc[(i + up) % NSEMI] += v;
			end else if (dn < up) begin
				acc[(i + NSEMI - dn) % NSEMI] += v;
			end else if (up <= MAX_REACH) begin
				// equal distance: truncated half each way, same target when opposite
				acc[(i + up) % NSEMI] += v >> 1;
				acc[(i + NSEMI - dn) % NSEMI] += v >> 1;
			end
		end
		for (i = 0; i < NSEMI; i++)
			r[i*W_BITS +: W_BITS] = W_BITS'(acc[i] > FULL_SCALE ? FULL_SCALE : acc[i]);
		return r;
	endfunction

	task automatic report_mismatch(string what);
		if (mismatches < MAX_PRINTS)
			$display("%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic weights_t fill(logic [W_BITS-1:0] v);
		weights_t w;
		for (int i = 0; i < NSEMI; i++)
			w[i*W_BITS +: W_BITS] = v;
		return w;
	endfunction

	function automatic weights_t one_hot(int idx, logic [W_BITS-1:0] v);
		weights_t w;
		w = '0;
		w[idx*W_BITS +: W_BITS] = v;
		return w;
	endfunction

	function automatic logic [W_BITS-1:0] rand_weight();
		case ($urandom_range(9))
			0: return '0;
			1: return W_BITS'($urandom_range(NOISE_FLOOR + 2));
			2: return W_BITS'(FULL_SCALE);
			3: return W_BITS'($urandom_range(65535));
			4: return W_BITS'($urandom_range(FULL_SCALE, FULL_SCALE - 64));
			default: return W_BITS'($urandom_range(FULL_SCALE));
		endcase
	endfunction

	function automatic weights_t rand_vector();
		weights_t w;
		bit sparse;
		sparse = ($urandom_range(7) == 0);
		for (int i = 0; i < NSEMI; i++)
			w[i*W_BITS +: W_BITS] = (sparse && $urandom_range(3) != 0) ? '0 : rand_weight();
		return w;
	endfunction

	function automatic logic [MASK_W-1:0] rand_mask();
		case ($urandom_range(2))
			0: return MASK_W'(1) << $urandom_range(NSEMI - 1);
			1: return (MASK_W'(1) << $urandom_range(NSEMI - 1)) |
				(MASK_W'(1) << $urandom_range(NSEMI - 1));
			default: return MASK_W'($urandom_range(4095));
		endcase
	endfunction

	// Idle once nothing is queued, offered or outstanding
	task automatic wait_idle();
		@(posedge clk);
		while (weight_backlog.size() != 0 || weights_valid || expected_moved.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_mask(logic [MASK_W-1:0] m);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sender: hold a request until taken, idle now and then outside the quiet stretch
	always @(negedge clk) begin
		if (arst_n && (!weights_valid || weights_taken)) begin
			if (weight_backlog.size() != 0 &&
				((weights_sent >= 400 && weights_sent < 700) || $urandom_range(99) >= 7)) begin
				weights       <= weight_backlog.pop_front();
				weights_valid <= 1'b1;
				weights_sent++;
			end else begin
				weights_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, a quiet stretch, and one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			moved_stall <= 1'b1;
			hold_left--;
		end else if (!hold_done && moved_seen >= 1000 && weight_backlog.size() > 50) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			moved_stall <= 1'b1;
		end else if (moved_seen >= 400 && moved_seen < 700) begin
			moved_stall <= 1'b0;
		end else begin
			moved_stall <= ($urandom_range(99) < 7);
		end
	end

	// Monitor: check results, record accepted requests and mask writes
	always @(posedge clk) begin
		moved_t want;
		weights_taken <= weights_valid && !weights_stall;
		if (arst_n) begin
			if (moved_valid && !moved_stall) begin
				moved_seen++;
				if (expected_moved.size() == 0) begin
					report_mismatch("moved request with nothing expected");
				end else begin
					want = expected_moved.pop_front();
					for (int i = 0; i < NSEMI; i++)
						if (moved[i*W_BITS +: W_BITS] !== want[i*W_BITS +: W_BITS])
							report_mismatch($sformatf("moved_%0d got %0d want %0d", i,
								moved[i*W_BITS +: W_BITS], want[i*W_BITS +: W_BITS]));
				end
			end
			if (weights_valid && !weights_stall)
				expected_moved.push_back(redistribute(weights, active_mask));
			if (cfg_valid && cfg_ready)
				active_mask = cfg_data;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Stimulus
	initial begin
		logic [MASK_W-1:0] m;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset mask: every weight stays in place, saturated at 1.0; all input bits toggled
		weight_backlog.push_back(fill(16'h0000));
		weight_backlog.push_back(fill(16'hFFFF));
		weight_backlog.push_back(fill(16'h8000));
		weight_backlog.push_back(fill(16'hAAAA));
		weight_backlog.push_back(fill(16'h5555));

		// empty scale drops everything
		write_mask(MASK_EMPTY);
		weight_backlog.push_back(fill(16'hFFFF));
		weight_backlog.push_back(fill(16'h8000));

		// single root: opposite tie at the tritone, floor edge, pile-up saturation
		write_mask(MASK_ROOT);
		weight_backlog.push_back(one_hot(6, 16'd9));
		weight_backlog.push_back(one_hot(6, 16'h8000));
		weight_backlog.push_back(one_hot(5, W_BITS'(NOISE_FLOOR)));
		weight_backlog.push_back(one_hot(5, W_BITS'(NOISE_FLOOR + 1)));
		weight_backlog.push_back(fill(W_BITS'(NOISE_FLOOR + 1)));
		weight_backlog.push_back(fill(16'h8000));

		// major scale: adjacent ties split both ways
		write_mask(MASK_MAJOR);
		weight_backlog.push_back(one_hot(1, 16'd7));
		weight_backlog.push_back(fill(16'h7FFF));
		weight_backlog.push_back(fill(W_BITS'(NOISE_FLOOR)));
		weight_backlog.push_back(fill(16'hFFFF));

		// random phases over fixed and random masks
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: m = MASK_EMPTY;
				1: m = MASK_FULL;
				2: m = MASK_ROOT;
				3: m = MASK_TOP;
				4: m = MASK_TRI;
				5: m = MASK_MAJOR;
				default: m = rand_mask();
			endcase
			write_mask(m);
			repeat (PHASE_ITEMS)
				weight_backlog.push_back(rand_vector());
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_moved.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
